// File: hdl/lqig_pkg.sv
// shared constants and codes for the loft quad index generator
`timescale 1ns / 1ps
package lqig_pkg;

	localparam int CFG_W     = 9;
	localparam int IDX_W     = 16;
	localparam int REG_IDX_W = 2;

	localparam int DEF_MAX_SECTIONS   = 256;
	localparam int DEF_MAX_RING_VERTS = 256;

	localparam logic [REG_IDX_W-1:0] REG_SECTION_COUNT  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_VERTS_PER_RING = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_CAPS_ENABLE    = 2'd2;

	localparam logic [CFG_W-1:0] SECTION_COUNT_RESET  = 9'd2;
	localparam logic [CFG_W-1:0] VERTS_PER_RING_RESET = 9'd4;
	localparam logic             CAPS_ENABLE_RESET    = 1'b0;

	localparam logic [1:0] PH_BODY  = 2'd0;
	localparam logic [1:0] PH_CAP   = 2'd1;
	localparam logic [1:0] PH_DEGEN = 2'd2;

endpackage

// File: hdl/lqig_in_if.sv
// input channel: one tick transaction carrying the restart flag
`timescale 1ns / 1ps
interface lqig_in_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

// File: hdl/lqig_out_if.sv
// output channel: one quad transaction with four vertex indices and a last flag
`timescale 1ns / 1ps
interface lqig_out_if;
	import lqig_pkg::*;

	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] index_a;
	logic [IDX_W-1:0] index_b;
	logic [IDX_W-1:0] index_c;
	logic [IDX_W-1:0] index_d;
	logic             last_quad;

	modport source (output valid, output index_a, output index_b, output index_c,
		output index_d, output last_quad, input ready);
	modport sink (input valid, input index_a, input index_b, input index_c,
		input index_d, input last_quad, output ready);
endinterface

// File: hdl/loft_quad_index_generator.sv
// an accepted tick has its quad in the output register in the next cycle
// throughput: one quad per cycle; a tick is taken whenever the output register
// is empty or being drained in the same cycle
// the position counters and one small multiply for the ring base set the cycle
// reset: configuration returns to two sections, four ring vertices, caps off;
// the sequence returns to the first body quad and the output register empties
`timescale 1ns / 1ps
module loft_quad_index_generator #(
	parameter int MAX_SECTIONS   = lqig_pkg::DEF_MAX_SECTIONS,
	parameter int MAX_RING_VERTS = lqig_pkg::DEF_MAX_RING_VERTS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	lqig_in_if.sink                        tick,
	lqig_out_if.source                     quad,
	input  logic                           cfg_we,
	input  logic [lqig_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [lqig_pkg::CFG_W-1:0]     cfg_data
);
	import lqig_pkg::*;

	localparam int SW  = $clog2(MAX_SECTIONS);
	localparam int VW  = $clog2(MAX_RING_VERTS);
	localparam int SCW = $clog2(MAX_SECTIONS + 1);
	localparam int VCW = $clog2(MAX_RING_VERTS + 1);

	logic [CFG_W-1:0] sec_count_q;
	logic [CFG_W-1:0] verts_q;
	logic             caps_q;

	logic [SW-1:0] sec_pos_q;
	logic [VW-1:0] vert_pos_q;
	logic [1:0]    phase_q;
	logic [VW-1:0] cap_pos_q;
	logic          cap_half_q;

	logic             out_valid_q;
	logic [IDX_W-1:0] idx_a_q, idx_b_q, idx_c_q, idx_d_q;
	logic             last_q;

	logic [SCW-1:0] s_cl;
	logic [VCW-1:0] v_cl;
	logic [VCW-1:0] h;
	logic           pos_ok;
	logic           go;

	logic [SW-1:0] e_sec, n_sec, sec_m1;
	logic [VW-1:0] e_vert, n_vert, j2;
	logic [1:0]    e_phase, n_phase;
	logic [VW-1:0] e_cap, n_cap;
	logic          e_half, n_half;
	logic          vert_inc_ok;
	logic          last;

	logic [31:0]      lo_full;
	logic [IDX_W-1:0] lo, hi, v16, h16, off;
	logic [IDX_W-1:0] qa, qb, qc, qd;

	logic accept;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_count_q <= SECTION_COUNT_RESET;
			verts_q     <= VERTS_PER_RING_RESET;
			caps_q      <= CAPS_ENABLE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SECTION_COUNT:  sec_count_q <= cfg_data;
				REG_VERTS_PER_RING: verts_q     <= cfg_data;
				REG_CAPS_ENABLE:    caps_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// clamped section count, ring size and half ring
	always_comb begin
		if (sec_count_q < CFG_W'(2))
			s_cl = SCW'(2);
		else if (32'(sec_count_q) > MAX_SECTIONS)
			s_cl = SCW'(MAX_SECTIONS);
		else
			s_cl = SCW'(sec_count_q);

		if (verts_q < CFG_W'(2))
			v_cl = VCW'(2);
		else if (32'(verts_q) > MAX_RING_VERTS)
			v_cl = VCW'(MAX_RING_VERTS);
		else
			v_cl = VCW'(verts_q);

		h = v_cl >> 1;
	end

	// current position still inside the sequence
	always_comb begin
		unique case (phase_q)
			PH_BODY:  pos_ok = (sec_pos_q != '0) && (32'(sec_pos_q) < 32'(s_cl)) &&
				(32'(vert_pos_q) < 32'(v_cl));
			PH_CAP:   pos_ok = caps_q && (cap_pos_q != '0) && (32'(cap_pos_q) < 32'(h));
			PH_DEGEN: pos_ok = caps_q && v_cl[0];
			default:  pos_ok = 1'b0;
		endcase
	end

	assign go      = tick.restart || !pos_ok;
	assign e_sec   = go ? SW'(1) : sec_pos_q;
	assign e_vert  = go ? '0 : vert_pos_q;
	assign e_phase = go ? PH_BODY : phase_q;
	assign e_cap   = go ? VW'(1) : cap_pos_q;
	assign e_half  = go ? 1'b0 : cap_half_q;

	// quad indices
	assign vert_inc_ok = (32'(e_vert) + 32'd1) < 32'(v_cl);
	assign j2          = vert_inc_ok ? e_vert + VW'(1) : '0;
	assign sec_m1      = e_sec - SW'(1);
	assign lo_full     = 32'(sec_m1) * 32'(v_cl);
	assign lo          = lo_full[IDX_W-1:0];
	assign v16         = IDX_W'(v_cl);
	assign h16         = IDX_W'(h);
	assign hi          = lo + v16;
	assign off         = e_half ? v16 : '0;

	always_comb begin
		unique case (e_phase)
			PH_BODY: begin
				qa = lo + IDX_W'(e_vert);
				qb = lo + IDX_W'(j2);
				qc = hi + IDX_W'(j2);
				qd = hi + IDX_W'(e_vert);
			end
			PH_CAP: begin
				qa = IDX_W'(e_cap) - IDX_W'(1) + off;
				qb = IDX_W'(e_cap) + off;
				qc = v16 - IDX_W'(e_cap) - IDX_W'(1) + off;
				qd = v16 - IDX_W'(e_cap) + off;
			end
			default: begin
				qa = h16 - IDX_W'(1) + off;
				qb = h16 + off;
				qc = h16 + off;
				qd = h16 + IDX_W'(1) + off;
			end
		endcase
	end

	// next position
	always_comb begin
		n_sec   = e_sec;
		n_vert  = e_vert;
		n_phase = e_phase;
		n_cap   = e_cap;
		n_half  = e_half;
		last    = 1'b0;
		unique case (e_phase)
			PH_BODY: begin
				if (vert_inc_ok) begin
					n_vert = e_vert + VW'(1);
				end else begin
					n_vert = '0;
					if ((32'(e_sec) + 32'd1) < 32'(s_cl)) begin
						n_sec = e_sec + SW'(1);
					end else if (caps_q && (h > VCW'(1))) begin
						n_phase = PH_CAP;
						n_cap   = VW'(1);
						n_half  = 1'b0;
					end else if (caps_q && v_cl[0]) begin
						n_phase = PH_DEGEN;
						n_half  = 1'b0;
					end else begin
						last = 1'b1;
					end
				end
			end
			PH_CAP: begin
				if (!e_half) begin
					n_half = 1'b1;
				end else begin
					n_half = 1'b0;
					if ((32'(e_cap) + 32'd1) < 32'(h))
						n_cap = e_cap + VW'(1);
					else if (v_cl[0])
						n_phase = PH_DEGEN;
					else
						last = 1'b1;
				end
			end
			default: begin
				if (!e_half)
					n_half = 1'b1;
				else
					last = 1'b1;
			end
		endcase
	end

	assign tick.ready = !out_valid_q || quad.ready;
	assign accept     = tick.valid && tick.ready;

	// position state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_pos_q  <= SW'(1);
			vert_pos_q <= '0;
			phase_q    <= PH_BODY;
			cap_pos_q  <= VW'(1);
			cap_half_q <= 1'b0;
		end else if (accept) begin
			if (last) begin
				sec_pos_q  <= SW'(1);
				vert_pos_q <= '0;
				phase_q    <= PH_BODY;
				cap_pos_q  <= VW'(1);
				cap_half_q <= 1'b0;
			end else begin
				sec_pos_q  <= n_sec;
				vert_pos_q <= n_vert;
				phase_q    <= n_phase;
				cap_pos_q  <= n_cap;
				cap_half_q <= n_half;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (accept)
			out_valid_q <= 1'b1;
		else if (quad.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_a_q <= qa;
			idx_b_q <= qb;
			idx_c_q <= qc;
			idx_d_q <= qd;
			last_q  <= last;
		end
	end

	assign quad.valid     = out_valid_q;
	assign quad.index_a   = idx_a_q;
	assign quad.index_b   = idx_b_q;
	assign quad.index_c   = idx_c_q;
	assign quad.index_d   = idx_d_q;
	assign quad.last_quad = last_q;

endmodule

// File: hdl/lqig_checker.sv
// port-level checker for the loft quad index generator and its bind
`timescale 1ns / 1ps
module lqig_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       in_restart,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [lqig_pkg::IDX_W-1:0] out_index_a,
	input logic [lqig_pkg::IDX_W-1:0] out_index_b,
	input logic [lqig_pkg::IDX_W-1:0] out_index_c,
	input logic [lqig_pkg::IDX_W-1:0] out_index_d,
	input logic                       out_last_quad
);
	import lqig_pkg::*;

	// stalled quad stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_index_a) &&
		$stable(out_index_b) && $stable(out_index_c) && $stable(out_index_d) &&
		$stable(out_last_quad))
		else $error("quad changed while stalled");

	// empty output register always takes a tick
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("not ready with empty output");

	// every accepted tick yields a quad in the next cycle
	a_tick_to_quad: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted tick gave no quad");

	// a restart begins at the first body quad
	a_restart_first: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_restart |=> out_index_a == '0 &&
		out_index_b == IDX_W'(1))
		else $error("restart did not give the first quad");

	// drained output with no new transaction empties
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !(in_valid && in_ready) |=> !out_valid)
		else $error("quad repeated after drain");

endmodule

bind loft_quad_index_generator lqig_checker u_lqig_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (tick.valid),
	.in_ready      (tick.ready),
	.in_restart    (tick.restart),
	.out_valid     (quad.valid),
	.out_ready     (quad.ready),
	.out_index_a   (quad.index_a),
	.out_index_b   (quad.index_b),
	.out_index_c   (quad.index_c),
	.out_index_d   (quad.index_d),
	.out_last_quad (quad.last_quad)
);
